// ===== src/bmp24_pkg.sv =====
package bmp24_pkg;

    // Default picture limits
    localparam int MaxWidthDef  = 4096;
    localparam int MaxHeightDef = 4096;

    // Dimension fields in a command hold values up to 65535
    localparam int DimW = 16;

    // Header layout
    localparam logic [31:0] HdrLastPos  = 32'd53;
    localparam logic [31:0] HdrSize     = 32'd54;
    localparam logic [15:0] BitDepth24  = 16'd24;
    localparam logic [7:0]  SigB        = 8'h42;
    localparam logic [7:0]  SigM        = 8'h4D;
    localparam logic [7:0]  AlphaOpaque = 8'd255;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SIGNATURE = 3'd1;
    localparam logic [2:0] ERR_FORMAT    = 3'd2;
    localparam logic [2:0] ERR_SIZE      = 3'd3;
    localparam logic [2:0] ERR_OFFSET    = 3'd4;

    // Parser phases
    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_HEADER = 6'b000010,
        PH_SKIP   = 6'b000100,
        PH_PIXELS = 6'b001000,
        PH_PAD    = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    // Command from parser to output side
    // header: dim_a = width, dim_b = height
    // pixel:  dim_a = width, dim_b = row from top, col = column
    typedef struct packed {
        logic [1:0]      kind;
        logic [2:0]      err;
        logic [DimW-1:0] dim_a;
        logic [DimW-1:0] dim_b;
        logic [DimW-1:0] col;
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
        logic            last;
    } t_cmd;

endpackage

// ===== src/bmp24_front.sv =====
module bmp24_front
    import bmp24_pkg::*;
#(
    parameter int MAX_WIDTH  = MaxWidthDef,
    parameter int MAX_HEIGHT = MaxHeightDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_byte,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    t_phase      r_phase, n_phase, c_phase;
    logic [31:0] r_pos, n_pos, c_pos;
    logic [31:0] r_off, n_off, c_off;
    logic [31:0] r_wid, n_wid, c_wid;
    logic [31:0] r_hgt, n_hgt, c_hgt;
    logic [15:0] r_bpp, n_bpp, c_bpp;
    logic [31:0] r_cmp, n_cmp, c_cmp;
    logic [WW-1:0] r_col, n_col, c_col;
    logic [HW-1:0] r_row, n_row, c_row;
    logic [1:0]  r_comp, n_comp, c_comp;
    logic [1:0]  r_pad, n_pad, c_pad;
    logic [7:0]  r_hb, n_hb;
    logic [7:0]  r_hg, n_hg;

    logic [1:0]    k_off, k_wid, k_hgt, k_bpp, k_cmp;
    logic          last_col, last_row;
    logic [HW-1:0] y_pos;
    logic          wid_bad, hgt_bad;

    // Current view of state: a first byte restarts the parser
    always_comb begin
        if (i_first_byte) begin
            c_phase = PH_HEADER;
            c_pos   = '0;
            c_off   = '0;
            c_wid   = '0;
            c_hgt   = '0;
            c_bpp   = '0;
            c_cmp   = '0;
            c_col   = '0;
            c_row   = '0;
            c_comp  = '0;
            c_pad   = '0;
        end else begin
            c_phase = r_phase;
            c_pos   = r_pos;
            c_off   = r_off;
            c_wid   = r_wid;
            c_hgt   = r_hgt;
            c_bpp   = r_bpp;
            c_cmp   = r_cmp;
            c_col   = r_col;
            c_row   = r_row;
            c_comp  = r_comp;
            c_pad   = r_pad;
        end
    end

    // Byte lanes of little-endian header fields
    assign k_off = 2'(c_pos - 32'd10);
    assign k_wid = 2'(c_pos - 32'd18);
    assign k_hgt = 2'(c_pos - 32'd22);
    assign k_bpp = 2'(c_pos - 32'd28);
    assign k_cmp = 2'(c_pos - 32'd30);

    assign wid_bad = c_wid[31] || (c_wid == '0) || (c_wid > 32'(MAX_WIDTH));
    assign hgt_bad = c_hgt[31] || (c_hgt == '0) || (c_hgt > 32'(MAX_HEIGHT));

    // Pixel position bookkeeping
    assign last_col = ((c_col + 1'b1) == c_wid[WW-1:0]);
    assign last_row = ((c_row + 1'b1) == c_hgt[HW-1:0]);
    assign y_pos    = c_hgt[HW-1:0] - 1'b1 - c_row;

    // Parse one byte
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_off   = r_off;
        n_wid   = r_wid;
        n_hgt   = r_hgt;
        n_bpp   = r_bpp;
        n_cmp   = r_cmp;
        n_col   = r_col;
        n_row   = r_row;
        n_comp  = r_comp;
        n_pad   = r_pad;
        n_hb    = r_hb;
        n_hg    = r_hg;
        o_push  = 1'b0;
        o_cmd   = '0;
        if (i_take) begin
            n_phase = c_phase;
            n_pos   = c_pos;
            n_off   = c_off;
            n_wid   = c_wid;
            n_hgt   = c_hgt;
            n_bpp   = c_bpp;
            n_cmp   = c_cmp;
            n_col   = c_col;
            n_row   = c_row;
            n_comp  = c_comp;
            n_pad   = c_pad;
            if (i_first_byte) begin
                n_hb = '0;
                n_hg = '0;
            end
            unique case (c_phase)
                PH_HEADER: begin
                    if (c_pos >= 32'd10 && c_pos < 32'd14) n_off[k_off*8 +: 8] = i_data_byte;
                    if (c_pos >= 32'd18 && c_pos < 32'd22) n_wid[k_wid*8 +: 8] = i_data_byte;
                    if (c_pos >= 32'd22 && c_pos < 32'd26) n_hgt[k_hgt*8 +: 8] = i_data_byte;
                    if (c_pos >= 32'd28 && c_pos < 32'd30) n_bpp[k_bpp[0]*8 +: 8] = i_data_byte;
                    if (c_pos >= 32'd30 && c_pos < 32'd34) n_cmp[k_cmp*8 +: 8] = i_data_byte;
                    n_pos = c_pos + 32'd1;
                    if ((c_pos == 32'd0 && i_data_byte != SigB) ||
                        (c_pos == 32'd1 && i_data_byte != SigM)) begin
                        o_push    = 1'b1;
                        o_cmd.kind = KIND_ERROR;
                        o_cmd.err  = ERR_SIGNATURE;
                        n_phase   = PH_DONE;
                    end else if (c_pos == HdrLastPos) begin
                        o_push = 1'b1;
                        priority if (c_bpp != BitDepth24 || c_cmp != '0) begin
                            o_cmd.kind = KIND_ERROR;
                            o_cmd.err  = ERR_FORMAT;
                            n_phase    = PH_DONE;
                        end else if (wid_bad || hgt_bad) begin
                            o_cmd.kind = KIND_ERROR;
                            o_cmd.err  = ERR_SIZE;
                            n_phase    = PH_DONE;
                        end else if (c_off < HdrSize) begin
                            o_cmd.kind = KIND_ERROR;
                            o_cmd.err  = ERR_OFFSET;
                            n_phase    = PH_DONE;
                        end else begin
                            o_cmd.kind  = KIND_HEADER;
                            o_cmd.dim_a = c_wid[DimW-1:0];
                            o_cmd.dim_b = c_hgt[DimW-1:0];
                            n_phase     = (c_off == HdrSize) ? PH_PIXELS : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    n_pos = c_pos + 32'd1;
                    if (n_pos == c_off) n_phase = PH_PIXELS;
                end
                PH_PAD: begin
                    if (c_pad != '0) n_pad = c_pad - 2'd1;
                    if (n_pad == '0) n_phase = PH_PIXELS;
                end
                PH_PIXELS: begin
                    priority if (c_comp == 2'd0) begin
                        n_hb   = i_data_byte;
                        n_comp = 2'd1;
                    end else if (c_comp == 2'd1) begin
                        n_hg   = i_data_byte;
                        n_comp = 2'd2;
                    end else begin
                        n_comp      = 2'd0;
                        o_push      = 1'b1;
                        o_cmd.kind  = KIND_PIXEL;
                        o_cmd.dim_a = c_wid[DimW-1:0];
                        o_cmd.dim_b = DimW'(y_pos);
                        o_cmd.col   = DimW'(c_col);
                        o_cmd.red   = i_data_byte;
                        o_cmd.green = r_hg;
                        o_cmd.blue  = r_hb;
                        o_cmd.last  = last_col && last_row;
                        priority if (!last_col) begin
                            n_col = c_col + 1'b1;
                        end else if (last_row) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_col = '0;
                            n_row = c_row + 1'b1;
                            n_pad = c_wid[1:0];
                            if (c_wid[1:0] != 2'd0) n_phase = PH_PAD;
                        end
                    end
                end
                PH_IDLE, PH_DONE: begin
                    n_phase = c_phase;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Advance parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_off   <= '0;
            r_wid   <= '0;
            r_hgt   <= '0;
            r_bpp   <= '0;
            r_cmp   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_comp  <= '0;
            r_pad   <= '0;
            r_hb    <= '0;
            r_hg    <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_off   <= n_off;
            r_wid   <= n_wid;
            r_hgt   <= n_hgt;
            r_bpp   <= n_bpp;
            r_cmp   <= n_cmp;
            r_col   <= n_col;
            r_row   <= n_row;
            r_comp  <= n_comp;
            r_pad   <= n_pad;
            r_hb    <= n_hb;
            r_hg    <= n_hg;
        end
    end

endmodule

// ===== src/bmp24_cmdq.sv =====
module bmp24_cmdq
    import bmp24_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store transactions
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("cmdq push while full");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("cmdq count out of range");
`endif

endmodule

// ===== src/bmp24_back.sv =====
module bmp24_back
    import bmp24_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_error_code,
    output logic [12:0] o_picture_width,
    output logic [12:0] o_picture_height,
    output logic [23:0] o_pixel_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_last_pixel
);

    logic              r_s1_v;
    t_cmd              r_s1;
    logic [2*DimW-1:0] r_prod;
    logic              r_o_v;
    logic              s1_rdy, s2_rdy;
    logic              is_pix, is_hdr;

    assign s2_rdy  = !r_o_v || i_pop;
    assign s1_rdy  = !r_s1_v || s2_rdy;
    assign o_q_pop = !i_q_empty && s1_rdy;
    assign o_empty = !r_o_v;
    assign is_pix  = (r_s1.kind == KIND_PIXEL);
    assign is_hdr  = (r_s1.kind == KIND_HEADER);

    // Stage 1: row offset product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_rdy) begin
            r_s1_v <= o_q_pop;
        end
        if (o_q_pop) begin
            r_s1   <= i_q_cmd;
            r_prod <= i_q_cmd.dim_b * i_q_cmd.dim_a;
        end
    end

    // Stage 2: result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s2_rdy) begin
            r_o_v <= r_s1_v;
        end
        if (s2_rdy && r_s1_v) begin
            o_result_kind    <= r_s1.kind;
            o_error_code     <= r_s1.err;
            o_picture_width  <= is_hdr ? r_s1.dim_a[12:0] : '0;
            o_picture_height <= is_hdr ? r_s1.dim_b[12:0] : '0;
            o_pixel_index    <= is_pix ? (r_prod[23:0] + 24'(r_s1.col)) : '0;
            o_red            <= r_s1.red;
            o_green          <= r_s1.green;
            o_blue           <= r_s1.blue;
            o_alpha          <= is_pix ? AlphaOpaque : '0;
            o_last_pixel     <= r_s1.last;
        end
    end

`ifndef NO_ASSERTIONS
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s2_rdy) |=> r_s1_v)
        else $error("stage 1 transaction lost under stall");
`endif

endmodule

// ===== src/bmp24_stream_decoder_core.sv =====
// A result reaches the output ports through the command queue, stage 1 and stage 2.
// Throughput: one byte per cycle; full rises only when the 4-entry command
// queue between parser and output pipeline is full, i.e. the consumer stalls.
// The pixel index takes one multiply stage and one add stage after the queue.
// Reset (i_rst_n low, synchronous): parser idle until a first byte, all queues empty.
module bmp24_stream_decoder_core
    import bmp24_pkg::*;
#(
    parameter int MAX_WIDTH  = MaxWidthDef,
    parameter int MAX_HEIGHT = MaxHeightDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_error_code,
    output logic [12:0] o_picture_width,
    output logic [12:0] o_picture_height,
    output logic [23:0] o_pixel_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_last_pixel
);

    logic take, f_push, q_empty, q_pop;
    t_cmd f_cmd, q_cmd;

    assign take = i_push && !o_full;

    // Parser
    bmp24_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .o_push       (f_push),
        .o_cmd        (f_cmd)
    );

    // Command queue
    bmp24_cmdq #(
        .DEPTH (4)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    // Output pipeline
    bmp24_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_cmd          (q_cmd),
        .o_q_pop          (q_pop),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_result_kind    (o_result_kind),
        .o_error_code     (o_error_code),
        .o_picture_width  (o_picture_width),
        .o_picture_height (o_picture_height),
        .o_pixel_index    (o_pixel_index),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue),
        .o_alpha          (o_alpha),
        .o_last_pixel     (o_last_pixel)
    );

endmodule
